[rtl/core/seag_pkg.sv]
// Shared types, codes and constants for the secure element access gate.
`default_nettype none
package seag_pkg;

  localparam int unsigned TIME_W   = 24;
  localparam int unsigned INS_W    = 8;
  localparam int unsigned COUNT_W  = 8;
  localparam int unsigned SEEN_W   = 3;
  localparam int unsigned CFG_IDX_W = 3;

  // Event codes carried in the operation field
  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_STATUS  = 2'd1,
    OP_CRYPTO  = 2'd2,
    OP_COMMAND = 2'd3
  } seag_op_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACCESS_BLOCK_TICKS = 3'd0,
    REG_CRYPTO_OP_TIMEOUT  = 3'd1,
    REG_SMALLEST_TIMEOUT   = 3'd2,
    REG_UPGRADE_TIMEOUT    = 3'd3,
    REG_REGULAR_TIMEOUT    = 3'd4,
    REG_BOOT_END_COMMAND   = 3'd5
  } seag_reg_t;

  // Allowlisted early-boot instructions, the update status bit, the all-seen mask and the count limit
  localparam logic [INS_W-1:0]   INS_A      = 8'hD9;
  localparam logic [INS_W-1:0]   INS_B      = 8'h2A;
  localparam logic [INS_W-1:0]   INS_C      = 8'h2D;
  localparam logic [7:0]         UPDATE_BIT = 8'h02;
  localparam logic [SEEN_W-1:0]  ALL_SEEN   = 3'd7;
  localparam logic [COUNT_W-1:0] COUNT_MAX  = 8'd255;

  // Reset values of the configuration registers
  localparam logic [TIME_W-1:0] RST_BLOCK_TICKS = 24'd1000;
  localparam logic [TIME_W-1:0] RST_CRYPTO_TO   = 24'd1000;
  localparam logic [TIME_W-1:0] RST_SMALLEST_TO = 24'd0;
  localparam logic [TIME_W-1:0] RST_UPGRADE_TO  = 24'd1000;
  localparam logic [TIME_W-1:0] RST_REGULAR_TO  = 24'd1000;
  localparam logic [INS_W-1:0]  RST_BOOT_END    = 8'd0;

  typedef struct packed {
    logic [TIME_W-1:0] access_block_ticks;
    logic [TIME_W-1:0] crypto_op_timeout;
    logic [TIME_W-1:0] smallest_timeout;
    logic [TIME_W-1:0] upgrade_timeout;
    logic [TIME_W-1:0] regular_timeout;
    logic [INS_W-1:0]  boot_end_command;
  } seag_cfg_t;

  typedef struct packed {
    seag_op_t          operation;
    logic [7:0]        status_byte;
    logic              op_begin;
    logic [INS_W-1:0]  command_ins;
  } seag_item_t;

  typedef struct packed {
    logic               command_allowed;
    logic               select_ok;
    logic [TIME_W-1:0]  session_timeout;
    logic               update_active;
    logic [COUNT_W-1:0] crypto_ops;
    logic               boot_over;
  } seag_result_t;

endpackage
`default_nettype wire

[rtl/core/seag_cfg_regs.sv]
// Configuration register file for the access gate.
`default_nettype none
module seag_cfg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [seag_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [seag_pkg::TIME_W-1:0]   cfg_data,
  output seag_pkg::seag_cfg_t                cfg
);

  seag_pkg::seag_cfg_t cfg_r;
  logic                wr_en;

  // Writes are always taken
  assign cfg_ready = 1'b1;
  assign wr_en     = cfg_valid;
  assign cfg       = cfg_r;

  // Register writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.access_block_ticks <= seag_pkg::RST_BLOCK_TICKS;
      cfg_r.crypto_op_timeout  <= seag_pkg::RST_CRYPTO_TO;
      cfg_r.smallest_timeout   <= seag_pkg::RST_SMALLEST_TO;
      cfg_r.upgrade_timeout    <= seag_pkg::RST_UPGRADE_TO;
      cfg_r.regular_timeout    <= seag_pkg::RST_REGULAR_TO;
      cfg_r.boot_end_command   <= seag_pkg::RST_BOOT_END;
    end else if (wr_en) begin
      case (cfg_index)
        seag_pkg::REG_ACCESS_BLOCK_TICKS: cfg_r.access_block_ticks <= cfg_data;
        seag_pkg::REG_CRYPTO_OP_TIMEOUT:  cfg_r.crypto_op_timeout  <= cfg_data;
        seag_pkg::REG_SMALLEST_TIMEOUT:   cfg_r.smallest_timeout   <= cfg_data;
        seag_pkg::REG_UPGRADE_TIMEOUT:    cfg_r.upgrade_timeout    <= cfg_data;
        seag_pkg::REG_REGULAR_TIMEOUT:    cfg_r.regular_timeout    <= cfg_data;
        seag_pkg::REG_BOOT_END_COMMAND:
          cfg_r.boot_end_command <= cfg_data[seag_pkg::INS_W-1:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/core/seag_gate_state.sv]
// Access gate state registers and the single-pass event update logic.
`default_nettype none
module seag_gate_state (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    step,
  input  wire seag_pkg::seag_item_t    item,
  input  wire seag_pkg::seag_cfg_t     cfg,
  output seag_pkg::seag_result_t       result
);

  logic                                access_open_r, access_open_nxt;
  logic                                update_flag_r, update_flag_nxt;
  logic                                boot_done_r, boot_done_nxt;
  logic [seag_pkg::SEEN_W-1:0]         seen_r, seen_nxt;
  logic [seag_pkg::COUNT_W-1:0]        count_r, count_nxt;
  logic                                blk_armed_r, blk_armed_nxt;
  logic [seag_pkg::TIME_W-1:0]         blk_rem_r, blk_rem_nxt;
  logic                                cry_armed_r, cry_armed_nxt;
  logic [seag_pkg::TIME_W-1:0]         cry_rem_r, cry_rem_nxt;
  logic                                allowed;
  logic [seag_pkg::SEEN_W-1:0]         ins_bit;
  logic [seag_pkg::SEEN_W-1:0]         seen_or;

  // Map an allowlisted instruction to its seen bit
  always_comb begin
    if (item.command_ins == seag_pkg::INS_A) begin
      ins_bit = 3'b001;
    end else if (item.command_ins == seag_pkg::INS_B) begin
      ins_bit = 3'b010;
    end else if (item.command_ins == seag_pkg::INS_C) begin
      ins_bit = 3'b100;
    end else begin
      ins_bit = '0;
    end
  end

  assign seen_or = seen_r | ins_bit;

  // Next state for one event
  always_comb begin
    access_open_nxt = access_open_r;
    update_flag_nxt = update_flag_r;
    boot_done_nxt   = boot_done_r;
    seen_nxt        = seen_r;
    count_nxt       = count_r;
    blk_armed_nxt   = blk_armed_r;
    blk_rem_nxt     = blk_rem_r;
    cry_armed_nxt   = cry_armed_r;
    cry_rem_nxt     = cry_rem_r;
    allowed         = 1'b0;
    case (item.operation)
      seag_pkg::OP_TICK: begin
        // Block timer: expiry reopens access
        if (blk_armed_r) begin
          if (blk_rem_r <= seag_pkg::TIME_W'(1)) begin
            blk_armed_nxt   = 1'b0;
            blk_rem_nxt     = '0;
            access_open_nxt = 1'b1;
          end else begin
            blk_rem_nxt = blk_rem_r - seag_pkg::TIME_W'(1);
          end
        end
        // Crypto timer: expiry clears the count
        if (cry_armed_r) begin
          if (cry_rem_r <= seag_pkg::TIME_W'(1)) begin
            cry_armed_nxt = 1'b0;
            cry_rem_nxt   = '0;
            count_nxt     = '0;
          end else begin
            cry_rem_nxt = cry_rem_r - seag_pkg::TIME_W'(1);
          end
        end
      end
      seag_pkg::OP_STATUS: begin
        if ((item.status_byte & seag_pkg::UPDATE_BIT) == seag_pkg::UPDATE_BIT) begin
          update_flag_nxt = 1'b1;
          access_open_nxt = 1'b0;
          blk_armed_nxt   = 1'b1;
          blk_rem_nxt     = cfg.access_block_ticks;
        end else begin
          update_flag_nxt = 1'b0;
          access_open_nxt = 1'b1;
          blk_armed_nxt   = 1'b0;
          blk_rem_nxt     = '0;
        end
      end
      seag_pkg::OP_CRYPTO: begin
        if (item.op_begin) begin
          // Saturating count; every start re-arms the timer
          if (count_r != seag_pkg::COUNT_MAX) begin
            count_nxt = count_r + seag_pkg::COUNT_W'(1);
          end
          cry_armed_nxt = 1'b1;
          cry_rem_nxt   = cfg.crypto_op_timeout;
        end else begin
          if (count_r != '0) begin
            count_nxt = count_r - seag_pkg::COUNT_W'(1);
          end
          if (count_r <= seag_pkg::COUNT_W'(1)) begin
            cry_armed_nxt = 1'b0;
            cry_rem_nxt   = '0;
          end
        end
      end
      seag_pkg::OP_COMMAND: begin
        if (access_open_r) begin
          allowed = 1'b1;
        end else if (!boot_done_r && (ins_bit != '0)) begin
          // Blocked in early boot: record allowlisted command
          seen_nxt = seen_or;
          allowed  = 1'b1;
          if (seen_or == seag_pkg::ALL_SEEN) begin
            boot_done_nxt = 1'b1;
          end
        end
        if (item.command_ins == cfg.boot_end_command) begin
          allowed = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Result from the state after the event
  always_comb begin
    result.command_allowed = allowed;
    result.select_ok       = access_open_nxt | ~boot_done_nxt;
    result.update_active   = update_flag_nxt;
    result.crypto_ops      = count_nxt;
    result.boot_over       = boot_done_nxt;
    if (update_flag_nxt) begin
      result.session_timeout = boot_done_nxt ? cfg.smallest_timeout : cfg.upgrade_timeout;
    end else begin
      result.session_timeout = (count_nxt != '0) ? cfg.crypto_op_timeout
                                                 : cfg.regular_timeout;
    end
  end

  // State registers, updated once per stepped event
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      access_open_r <= 1'b1;
      update_flag_r <= 1'b0;
      boot_done_r   <= 1'b0;
      seen_r        <= '0;
      count_r       <= '0;
      blk_armed_r   <= 1'b0;
      blk_rem_r     <= '0;
      cry_armed_r   <= 1'b0;
      cry_rem_r     <= '0;
    end else if (step) begin
      access_open_r <= access_open_nxt;
      update_flag_r <= update_flag_nxt;
      boot_done_r   <= boot_done_nxt;
      seen_r        <= seen_nxt;
      count_r       <= count_nxt;
      blk_armed_r   <= blk_armed_nxt;
      blk_rem_r     <= blk_rem_nxt;
      cry_armed_r   <= cry_armed_nxt;
      cry_rem_r     <= cry_rem_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/core/secure_element_access_gate_core.sv]
// Top level of the secure element access gate: input register, gate logic, result register.
//
//  Channel  | Direction | Handshake            | Payload
//  ---------+-----------+----------------------+---------------------------------------
//  in_      | input     | in_valid / in_ready  | operation, status_byte, op_begin,
//           |           |                      | command_ins
//  out_     | output    | out_valid / out_ready| command_allowed, select_ok,
//           |           |                      | session_timeout, update_active,
//           |           |                      | crypto_ops, boot_over
//  cfg_     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data (always ready)
//
// An accepted event waits in the input register until the result register is free or
// being emptied; the gate logic then loads the result register. One event per cycle
// sustained while the result side does not stall. Reset is synchronous on rst_n and
// needs no clearing pass. A stalled result register holds its transaction; the input
// register takes an event while it is empty or the result register is free or draining.
`default_nettype none
module secure_element_access_gate_core (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // Input channel
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [1:0]                      in_operation,
  input  wire logic [7:0]                      in_status_byte,
  input  wire logic                            in_op_begin,
  input  wire logic [seag_pkg::INS_W-1:0]      in_command_ins,
  // Result channel
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 out_command_allowed,
  output logic                                 out_select_ok,
  output logic [seag_pkg::TIME_W-1:0]          out_session_timeout,
  output logic                                 out_update_active,
  output logic [seag_pkg::COUNT_W-1:0]         out_crypto_ops,
  output logic                                 out_boot_over,
  // Configuration channel
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [seag_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [seag_pkg::TIME_W-1:0]     cfg_data
);

  seag_pkg::seag_cfg_t    cfg;
  seag_pkg::seag_item_t   item_r;
  seag_pkg::seag_result_t result;
  seag_pkg::seag_result_t res_r;
  logic                   item_valid_r;
  logic                   out_valid_r;
  logic                   step;

  seag_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Event moves into the result register when that register is free or draining
  assign step     = item_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !item_valid_r || step;

  seag_gate_state u_state (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (item_r),
    .cfg    (cfg),
    .result (result)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_ready) begin
      item_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.operation   <= seag_pkg::seag_op_t'(in_operation);
      item_r.status_byte <= in_status_byte;
      item_r.op_begin    <= in_op_begin;
      item_r.command_ins <= in_command_ins;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= result;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_command_allowed = res_r.command_allowed;
  assign out_select_ok       = res_r.select_ok;
  assign out_session_timeout = res_r.session_timeout;
  assign out_update_active   = res_r.update_active;
  assign out_crypto_ops      = res_r.crypto_ops;
  assign out_boot_over       = res_r.boot_over;

endmodule
`default_nettype wire

[rtl/core/seag_port_checker.sv]
// Port-level checker for the access gate core and its bind.
`default_nettype none
module seag_port_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire logic                            out_select_ok,
  input wire logic [seag_pkg::TIME_W-1:0]     out_session_timeout,
  input wire logic                            out_boot_over
);

  // No result is presented right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid directly after reset");

  // A stalled result keeps its timeout
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_session_timeout))
    else $error("stalled result changed");

  // Early boot end stays reported in a result presented right after one that reported it
  a_boot_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_boot_over |=> !out_valid || out_boot_over)
    else $error("boot_over dropped after being reported");

  // Select is always allowed during early boot
  a_select_boot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_boot_over |-> out_select_ok)
    else $error("select blocked during early boot");

endmodule

bind secure_element_access_gate_core seag_port_checker u_seag_port_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_select_ok       (out_select_ok),
  .out_session_timeout (out_session_timeout),
  .out_boot_over       (out_boot_over)
);
`default_nettype wire

[sim/seag_gate_checker.sv]
// Access gate checker: watches all three channels, predicts every result and compares it.
module seag_gate_checker (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  input  wire logic                           in_ready,
  input  wire logic [1:0]                     in_operation,
  input  wire logic [7:0]                     in_status_byte,
  input  wire logic                           in_op_begin,
  input  wire logic [seag_pkg::INS_W-1:0]     in_command_ins,
  input  wire logic                           out_valid,
  input  wire logic                           out_ready,
  input  wire logic                           out_command_allowed,
  input  wire logic                           out_select_ok,
  input  wire logic [seag_pkg::TIME_W-1:0]    out_session_timeout,
  input  wire logic                           out_update_active,
  input  wire logic [seag_pkg::COUNT_W-1:0]   out_crypto_ops,
  input  wire logic                           out_boot_over,
  input  wire logic                           cfg_valid,
  input  wire logic                           cfg_ready,
  input  wire logic [seag_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [seag_pkg::TIME_W-1:0]    cfg_data,
  output int unsigned                         outstanding,
  output int unsigned                         fail_count,
  output int unsigned                         verdicts_checked
);

  // Shadow copy of the gate registers and state
  seag_pkg::seag_cfg_t              regs;
  logic                             gate_open;
  logic                             upd_flag;
  logic                             boot_done;
  logic [seag_pkg::SEEN_W-1:0]      allow_seen;
  logic [seag_pkg::COUNT_W-1:0]     ops;
  logic                             blk_armed;
  logic                             cry_armed;
  logic [seag_pkg::TIME_W-1:0]      blk_left;
  logic [seag_pkg::TIME_W-1:0]      cry_left;

  seag_pkg::seag_result_t           pending_verdicts[$];
  seag_pkg::seag_item_t             ev;
  seag_pkg::seag_result_t           want;

  // Advance the shadow gate by one event and return the result it should report
  function automatic seag_pkg::seag_result_t gate_step(input seag_pkg::seag_item_t e);
    seag_pkg::seag_result_t      r;
    logic [seag_pkg::SEEN_W-1:0] hit;
    r   = '0;
    hit = '0;
    case (e.operation)
      seag_pkg::OP_TICK: begin
        if (blk_armed) begin
          if (blk_left <= 1) begin
            blk_armed = 1'b0;
            blk_left  = '0;
            gate_open = 1'b1;
          end else begin
            blk_left = blk_left - 1'b1;
          end
        end
        if (cry_armed) begin
          if (cry_left <= 1) begin
            cry_armed = 1'b0;
            cry_left  = '0;
            ops       = '0;
          end else begin
            cry_left = cry_left - 1'b1;
          end
        end
      end
      seag_pkg::OP_STATUS: begin
        if ((e.status_byte & seag_pkg::UPDATE_BIT) == seag_pkg::UPDATE_BIT) begin
          upd_flag  = 1'b1;
          gate_open = 1'b0;
          blk_armed = 1'b1;
          blk_left  = regs.access_block_ticks;
        end else begin
          upd_flag  = 1'b0;
          gate_open = 1'b1;
          blk_armed = 1'b0;
          blk_left  = '0;
        end
      end
      seag_pkg::OP_CRYPTO: begin
        if (e.op_begin) begin
          // count saturates, timer re-arms regardless
          if (ops != seag_pkg::COUNT_MAX) ops = ops + 1'b1;
          cry_armed = 1'b1;
          cry_left  = regs.crypto_op_timeout;
        end else begin
          if (ops != '0) ops = ops - 1'b1;
          if (ops == '0) begin
            cry_armed = 1'b0;
            cry_left  = '0;
          end
        end
      end
      seag_pkg::OP_COMMAND: begin
        if (gate_open) begin
          r.command_allowed = 1'b1;
        end else if (!boot_done) begin
          // allowlisted commands are recorded only while blocked in early boot
          if (e.command_ins == seag_pkg::INS_A) hit = 3'b001;
          else if (e.command_ins == seag_pkg::INS_B) hit = 3'b010;
          else if (e.command_ins == seag_pkg::INS_C) hit = 3'b100;
          if (hit != '0) begin
            allow_seen = allow_seen | hit;
            if (allow_seen == seag_pkg::ALL_SEEN) boot_done = 1'b1;
            r.command_allowed = 1'b1;
          end
        end
        if (e.command_ins == regs.boot_end_command) r.command_allowed = 1'b1;
      end
      default: ;
    endcase
    r.select_ok = gate_open || !boot_done;
    if (upd_flag) r.session_timeout = boot_done ? regs.smallest_timeout : regs.upgrade_timeout;
    else r.session_timeout = (ops != '0) ? regs.crypto_op_timeout : regs.regular_timeout;
    r.update_active = upd_flag;
    r.crypto_ops    = ops;
    r.boot_over     = boot_done;
    return r;
  endfunction

  function automatic void field_check(input string name,
                                      input logic [seag_pkg::TIME_W-1:0] exp_val,
                                      input logic [seag_pkg::TIME_W-1:0] act_val);
    if (act_val !== exp_val) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, act_val);
      fail_count++;
    end
  endfunction

  // Results are checked before the new event is predicted; latency keeps them apart
  always @(posedge clk) begin
    if (!rst_n) begin
      regs.access_block_ticks = seag_pkg::RST_BLOCK_TICKS;
      regs.crypto_op_timeout  = seag_pkg::RST_CRYPTO_TO;
      regs.smallest_timeout   = seag_pkg::RST_SMALLEST_TO;
      regs.upgrade_timeout    = seag_pkg::RST_UPGRADE_TO;
      regs.regular_timeout    = seag_pkg::RST_REGULAR_TO;
      regs.boot_end_command   = seag_pkg::RST_BOOT_END;
      gate_open        = 1'b1;
      upd_flag         = 1'b0;
      boot_done        = 1'b0;
      allow_seen       = '0;
      ops              = '0;
      blk_armed        = 1'b0;
      cry_armed        = 1'b0;
      blk_left         = '0;
      cry_left         = '0;
      fail_count       = 0;
      verdicts_checked = 0;
      pending_verdicts.delete();
    end else begin
      // result transaction
      if (out_valid && out_ready) begin
        if (pending_verdicts.size() == 0) begin
          $display("%0t: unexpected result, allowed %0b select %0b timeout %0h",
                   $time, out_command_allowed, out_select_ok, out_session_timeout);
          $display("%0t: unexpected result, upd %0b ops %0d boot %0b",
                   $time, out_update_active, out_crypto_ops, out_boot_over);
          fail_count++;
        end else begin
          want = pending_verdicts.pop_front();
          verdicts_checked++;
          field_check("command_allowed", want.command_allowed, out_command_allowed);
          field_check("select_ok", want.select_ok, out_select_ok);
          field_check("session_timeout", want.session_timeout, out_session_timeout);
          field_check("update_active", want.update_active, out_update_active);
          field_check("crypto_ops", want.crypto_ops, out_crypto_ops);
          field_check("boot_over", want.boot_over, out_boot_over);
        end
      end
      // event transaction
      if (in_valid && in_ready) begin
        ev.operation   = seag_pkg::seag_op_t'(in_operation);
        ev.status_byte = in_status_byte;
        ev.op_begin    = in_op_begin;
        ev.command_ins = in_command_ins;
        pending_verdicts.push_back(gate_step(ev));
      end
      // register write transaction
      if (cfg_valid && cfg_ready) begin
        case (seag_pkg::seag_reg_t'(cfg_index))
          seag_pkg::REG_ACCESS_BLOCK_TICKS: regs.access_block_ticks = cfg_data;
          seag_pkg::REG_CRYPTO_OP_TIMEOUT:  regs.crypto_op_timeout  = cfg_data;
          seag_pkg::REG_SMALLEST_TIMEOUT:   regs.smallest_timeout   = cfg_data;
          seag_pkg::REG_UPGRADE_TIMEOUT:    regs.upgrade_timeout    = cfg_data;
          seag_pkg::REG_REGULAR_TIMEOUT:    regs.regular_timeout    = cfg_data;
          seag_pkg::REG_BOOT_END_COMMAND:
            regs.boot_end_command = cfg_data[seag_pkg::INS_W-1:0];
          default: ;
        endcase
      end
    end
    outstanding <= pending_verdicts.size();
  end

endmodule

[sim/secure_element_access_gate_core_tb.sv]
// Testbench top for the access gate core: events, register writes, stalls and the verdict.
module secure_element_access_gate_core_tb;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned HOLD_CYCLES  = 150;
  localparam int unsigned BURST_STARTS = 262;

  logic                           clk            = 1'b0;
  logic                           rst_n          = 1'b0;
  logic                           in_valid       = 1'b0;
  logic                           in_ready;
  logic [1:0]                     in_operation   = seag_pkg::OP_TICK;
  logic [7:0]                     in_status_byte = '0;
  logic                           in_op_begin    = 1'b0;
  logic [seag_pkg::INS_W-1:0]     in_command_ins = '0;
  logic                           out_valid;
  logic                           out_ready      = 1'b0;
  logic                           out_command_allowed;
  logic                           out_select_ok;
  logic [seag_pkg::TIME_W-1:0]    out_session_timeout;
  logic                           out_update_active;
  logic [seag_pkg::COUNT_W-1:0]   out_crypto_ops;
  logic                           out_boot_over;
  logic                           cfg_valid      = 1'b0;
  logic                           cfg_ready;
  logic [seag_pkg::CFG_IDX_W-1:0] cfg_index      = seag_pkg::REG_ACCESS_BLOCK_TICKS;
  logic [seag_pkg::TIME_W-1:0]    cfg_data       = '0;

  int unsigned outstanding;
  int unsigned fail_count;
  int unsigned verdicts_checked;
  int unsigned snd_idle_pct = 0;
  int unsigned rcv_idle_pct = 0;
  int unsigned hold_req_cnt = 0;
  int unsigned hold_served  = 0;
  int unsigned hold_left    = 0;
  int unsigned cycle_count  = 0;
  int unsigned events_sent  = 0;
  logic [seag_pkg::INS_W-1:0] cur_boot_end = seag_pkg::RST_BOOT_END;

  secure_element_access_gate_core u_top (.*);

  seag_gate_checker u_check (.*);

  always #5 clk = ~clk;

  // Result side: random stalls, plus a long hold-off whenever one is requested
  always @(posedge clk) begin
    if (hold_served != hold_req_cnt) begin
      hold_served <= hold_req_cnt;
      hold_left   <= HOLD_CYCLES;
      out_ready   <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("secure_element_access_gate_core test failed");
      $finish;
    end
  end

  // Offer one event; valid stays up until the transaction completes
  task automatic send_event(input seag_pkg::seag_op_t op, input logic [7:0] status,
                            input logic started, input logic [seag_pkg::INS_W-1:0] ins);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_status_byte <= status;
    in_op_begin    <= started;
    in_command_ins <= ins;
    do @(posedge clk); while (!in_ready);
    events_sent++;
  endtask

  // Weighted random event; unused fields always carry noise
  task automatic send_random_event();
    int unsigned                pick;
    int unsigned                ins_kind;
    seag_pkg::seag_op_t         op;
    logic [seag_pkg::INS_W-1:0] ins;
    pick     = $urandom_range(99);
    ins_kind = $urandom_range(9);
    if (pick < 35) op = seag_pkg::OP_TICK;
    else if (pick < 55) op = seag_pkg::OP_STATUS;
    else if (pick < 75) op = seag_pkg::OP_CRYPTO;
    else op = seag_pkg::OP_COMMAND;
    if (ins_kind == 0) begin
      ins = cur_boot_end;
    end else if (ins_kind == 1) begin
      case ($urandom_range(2))
        0:       ins = seag_pkg::INS_A;
        1:       ins = seag_pkg::INS_B;
        default: ins = seag_pkg::INS_C;
      endcase
    end else begin
      ins = 8'($urandom);
    end
    send_event(op, 8'($urandom), ($urandom_range(9) < 6), ins);
  endtask

  // Stop offering and wait until every predicted result has come out
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_reg(input seag_pkg::seag_reg_t idx,
                           input logic [seag_pkg::TIME_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic program_regs(input logic [seag_pkg::TIME_W-1:0] blk,
                              input logic [seag_pkg::TIME_W-1:0] cry,
                              input logic [seag_pkg::TIME_W-1:0] sml,
                              input logic [seag_pkg::TIME_W-1:0] upg,
                              input logic [seag_pkg::TIME_W-1:0] regular_to,
                              input logic [seag_pkg::INS_W-1:0]  bend);
    logic [seag_pkg::TIME_W-1:0] bend_word;
    // upper bits of the command write are junk on purpose
    bend_word = 24'($urandom);
    bend_word[seag_pkg::INS_W-1:0] = bend;
    write_reg(seag_pkg::REG_ACCESS_BLOCK_TICKS, blk);
    write_reg(seag_pkg::REG_CRYPTO_OP_TIMEOUT, cry);
    write_reg(seag_pkg::REG_SMALLEST_TIMEOUT, sml);
    write_reg(seag_pkg::REG_UPGRADE_TIMEOUT, upg);
    write_reg(seag_pkg::REG_REGULAR_TIMEOUT, regular_to);
    write_reg(seag_pkg::REG_BOOT_END_COMMAND, bend_word);
    cfg_valid    <= 1'b0;
    cur_boot_end = bend;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed events under reset register values
    send_event(seag_pkg::OP_TICK, 8'h00, 1'b0, 8'h00);        // tick with nothing armed
    send_event(seag_pkg::OP_COMMAND, 8'h00, 1'b0, 8'hFF);     // open: anything goes
    send_event(seag_pkg::OP_CRYPTO, 8'hFF, 1'b0, 8'hFF);      // finish with nothing running
    send_event(seag_pkg::OP_CRYPTO, 8'h00, 1'b1, 8'h00);
    send_event(seag_pkg::OP_CRYPTO, 8'h00, 1'b1, 8'h00);
    send_event(seag_pkg::OP_CRYPTO, 8'h00, 1'b0, 8'h00);
    send_event(seag_pkg::OP_STATUS, 8'hFD, 1'b1, 8'hFF);      // update bit clear, rest set
    // update starts, access blocked
    send_event(seag_pkg::OP_STATUS, seag_pkg::UPDATE_BIT, 1'b0, 8'h00);
    send_event(seag_pkg::OP_COMMAND, 8'hFF, 1'b1, seag_pkg::RST_BOOT_END);
    send_event(seag_pkg::OP_COMMAND, 8'h00, 1'b0, 8'hFF);     // blocked, not allowlisted
    send_event(seag_pkg::OP_COMMAND, 8'h00, 1'b0, seag_pkg::INS_A);
    send_event(seag_pkg::OP_COMMAND, 8'h00, 1'b0, seag_pkg::INS_A);   // repeat of a seen one
    send_event(seag_pkg::OP_COMMAND, 8'h00, 1'b0, seag_pkg::INS_B);
    send_event(seag_pkg::OP_COMMAND, 8'h00, 1'b0, seag_pkg::INS_C + 8'h01);
    send_event(seag_pkg::OP_TICK, 8'hFF, 1'b1, 8'hFF);
    send_event(seag_pkg::OP_STATUS, 8'hFF, 1'b0, 8'h00);      // re-arm block timer
    send_event(seag_pkg::OP_CRYPTO, 8'h00, 1'b1, 8'h00);
    send_event(seag_pkg::OP_STATUS, 8'h00, 1'b0, 8'h00);      // update cleared, access open
    // open: allowed but not recorded
    send_event(seag_pkg::OP_COMMAND, 8'h00, 1'b0, seag_pkg::INS_C);
    send_event(seag_pkg::OP_STATUS, seag_pkg::UPDATE_BIT, 1'b1, seag_pkg::INS_C);
    // third allowlisted: early boot ends
    send_event(seag_pkg::OP_COMMAND, 8'hFF, 1'b1, seag_pkg::INS_C);
    // after early boot: refused
    send_event(seag_pkg::OP_COMMAND, 8'h00, 1'b0, seag_pkg::INS_A);
    send_event(seag_pkg::OP_COMMAND, 8'h00, 1'b0, seag_pkg::RST_BOOT_END);
    send_event(seag_pkg::OP_STATUS, 8'h00, 1'b0, 8'h00);

    // Short timers, sender mostly busy, receiver mostly stalled
    drain();
    program_regs(24'd1, 24'd3, 24'd0, 24'hFFFFFF, 24'd5, 8'h00);
    snd_idle_pct =  10;
    rcv_idle_pct <= 77;
    repeat (100) send_random_event();
    hold_req_cnt <= hold_req_cnt + 1;
    repeat (100) send_random_event();

    // Zero-length timers, roles of the two sides swapped
    drain();
    program_regs(24'd0, 24'd0, 24'hFFFFFF, 24'd0, 24'hFFFFFF, 8'hFF);
    snd_idle_pct =  77;
    rcv_idle_pct <= 10;
    repeat (100) send_random_event();
    drain();
    repeat (100) send_random_event();

    // Timers that never run out, full rate both sides, crypto count driven to saturation
    drain();
    program_regs(24'hFFFFFF, 24'hFFFFFF, 24'($urandom), 24'($urandom), 24'd0, seag_pkg::INS_C);
    snd_idle_pct =  0;
    rcv_idle_pct <= 0;
    for (int i = 0; i < BURST_STARTS; i++) begin
      if ($urandom_range(7) == 0) begin
        send_event(seag_pkg::OP_COMMAND, 8'($urandom), 1'($urandom), 8'($urandom));
      end
      send_event(seag_pkg::OP_CRYPTO, 8'($urandom), 1'b1, 8'($urandom));
    end
    repeat (200) send_random_event();

    drain();
    repeat (8) @(posedge clk);
    $display("Ran %0d gate events: directed cases and random traffic under four register sets,",
             events_sent);
    $display("a %0d-start crypto burst and a long result hold-off; %0d results compared.",
             BURST_STARTS, verdicts_checked);
    if (fail_count == 0 && outstanding == 0) begin
      $display("secure_element_access_gate_core test passed");
    end else begin
      $display("secure_element_access_gate_core test failed");
    end
    $finish;
  end

endmodule
